@@ src/psc_pkg.sv @@
package psc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd5;

  // request kinds carried on the input tuser
  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_TMUL,
    ST_BND,
    ST_IMUL,
    ST_RDIV,
    ST_FDIV,
    ST_DMUL,
    ST_SUM,
    ST_CLR
  } state_e;

endpackage

@@ src/pid_speed_controller.sv @@
// pid speed controller, signed fixed point, one shared bit-serial multiplier and divider
// step order: proportional multiply, error times period, integral bound divide, integral
//   multiply, raw derivative divide, filter divide by five, derivative multiply, then the sum
//   and clamp into the output register; with zero integral gain or unordered limits the
//   bound divide is skipped; one beat is in flight at a time, paced by the serial passes;
//   the next beat is taken while a result waits
// reset: async active low, clears control state, loop state and restores default registers
module pid_speed_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [psc_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                   cfg_data_i,
  // input stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: setpoint, measurement, zero pad
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // tuser: req_type
  input  logic                                    s_axis_tuser,
  // output stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // tdata: drive, zero pad
  output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // tuser: limited
  output logic                                    m_axis_tuser
);
  import psc_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DN  = W + F + 2;          // dividend width for all three divides
  localparam int CW  = $clog2(DN + 1);
  localparam int ODW = ((W + 7) / 8) * 8;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0] PER_RST = (W-1)'(((64'd1 << F) + 64'd500) / 64'd1000);
  localparam logic [W-1:0] OUT_RST = W'(64'd1000 << F);

  // configuration registers
  logic signed [W-1:0] kp_q, ki_q, kd_q, ol_q, oh_q;
  logic        [W-2:0] per_q;

  // loop state and step scratch
  logic signed [W-1:0] integ_q, last_q, filt_q;
  logic signed [W-1:0] e_q, p_q, i_q, d_q, raw_q;

  // shared serial engine
  logic        [W-1:0]  mc_q, mp_q, acc_q;   // multiplicand, multiplier/low product, high product
  logic        [DN-1:0] dv_q;                // dividend shift register
  logic        [W-1:0]  dd_q;                // divisor
  logic        [W:0]    rem_q, quo_q;
  logic                 ovf_q, sgn_q, busy_q;
  logic        [CW-1:0] cnt_q;

  // output register
  logic                 mv_q, ml_q;
  logic signed [W-1:0]  md_q;

  state_e state_q, state_d;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      per_q <= PER_RST;
      ol_q  <= -OUT_RST;
      oh_q  <= OUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:  kp_q  <= cfg_data_i;
        REG_INTEG_GAIN: ki_q  <= cfg_data_i;
        REG_DERIV_GAIN: kd_q  <= cfg_data_i;
        REG_PERIOD:     per_q <= cfg_data_i[W-2:0];
        REG_OUT_LOW:    ol_q  <= cfg_data_i;
        REG_OUT_HIGH:   oh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
    mag_w = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [W-1:0] sat_w1(input logic signed [W:0] x);
    if (x[W] != x[W-1]) sat_w1 = x[W] ? MINV : MAXV;
    else sat_w1 = x[W-1:0];
  endfunction

  // ---------------------------------------------------------------- shared terms
  logic        [W-2:0] per_eff;
  logic signed [W:0]   span, e_full, rd_x;
  logic                span_le0, bnd_skip_c;
  logic        [W:0]   rd_mag;
  logic signed [W+2:0] fy;
  logic        [W+2:0] fy_mag;

  assign per_eff    = (per_q == '0) ? (W-1)'(1) : per_q;
  assign span       = {oh_q[W-1], oh_q} - {ol_q[W-1], ol_q};
  assign span_le0   = span[W] || (span == '0);
  assign bnd_skip_c = span_le0 || (ki_q == '0);
  assign rd_x       = {e_q[W-1], e_q} - {last_q[W-1], last_q};
  assign rd_mag     = rd_x[W] ? (~rd_x + 1'b1) : rd_x;
  // 4*old + raw ahead of the divide by five
  assign fy         = ({{3{filt_q[W-1]}}, filt_q} <<< 2) + {{3{raw_q[W-1]}}, raw_q};
  assign fy_mag     = fy[W+2] ? (~fy + 1'b1) : fy;
  assign e_full     = {s_axis_tdata[W-1], s_axis_tdata[W-1:0]}
                    - {s_axis_tdata[2*W-1], s_axis_tdata[2*W-1:W]};

  // ---------------------------------------------------------------- control
  logic is_mul, is_div, op_load, op_step, op_done, out_free, out_wr, in_acc;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = (s_axis_tuser == REQ_CLEAR) ? ST_CLR : ST_PMUL;
      ST_PMUL: if (op_done) state_d = ST_TMUL;
      ST_TMUL: if (op_done) state_d = ST_BND;
      ST_BND:  if (op_done || (!busy_q && bnd_skip_c)) state_d = ST_IMUL;
      ST_IMUL: if (op_done) state_d = ST_RDIV;
      ST_RDIV: if (op_done) state_d = ST_FDIV;
      ST_FDIV: if (op_done) state_d = ST_DMUL;
      ST_DMUL: if (op_done) state_d = ST_SUM;
      ST_SUM:  if (out_free) state_d = ST_IDLE;
      ST_CLR:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    is_mul   = (state_q == ST_PMUL) || (state_q == ST_TMUL)
            || (state_q == ST_IMUL) || (state_q == ST_DMUL);
    is_div   = (state_q == ST_RDIV) || (state_q == ST_FDIV)
            || ((state_q == ST_BND) && !bnd_skip_c);
    op_load  = (is_mul || is_div) && !busy_q;
    op_step  = busy_q && (cnt_q != '0);
    op_done  = busy_q && (cnt_q == '0);
    out_free = !mv_q || m_axis_tready;
    out_wr   = ((state_q == ST_SUM) || (state_q == ST_CLR)) && out_free;
    in_acc   = (state_q == ST_IDLE) && s_axis_tvalid;
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // ---------------------------------------------------------------- operand select
  logic signed [W-1:0] ma, mb;
  logic        [DN-1:0] dvn;
  logic        [W-1:0]  ddn;
  logic                 dneg;

  always_comb begin
    ma = kp_q;
    mb = e_q;
    unique case (state_q)
      ST_TMUL: begin ma = e_q;  mb = {1'b0, per_eff}; end
      ST_IMUL: begin ma = ki_q; mb = integ_q;         end
      ST_DMUL: begin ma = kd_q; mb = filt_q;          end
      default: ;
    endcase
  end

  always_comb begin
    dvn  = DN'(fy_mag);
    ddn  = W'(5);
    dneg = fy[W+2];
    unique case (state_q)
      ST_BND: begin
        dvn  = DN'(span) << F;
        ddn  = mag_w(ki_q);
        dneg = 1'b0;
      end
      ST_RDIV: begin
        dvn  = DN'(rd_mag) << F;
        ddn  = {1'b0, per_eff};
        dneg = rd_x[W];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- engine results
  logic        [W-1:0]     limv, mm, dm;
  logic        [2*W-1:0]   prod;
  logic        [2*W-F-1:0] qv;
  logic signed [W-1:0]     mres, dres;
  logic        [W:0]       msum, r2;
  logic                    ge;

  assign limv = sgn_q ? MINV : MAXV;
  assign prod = {acc_q, mp_q};
  assign qv   = prod[2*W-1:F];
  assign mm   = (qv > {{(W-F){1'b0}}, limv}) ? limv : qv[W-1:0];
  assign mres = sgn_q ? (~mm + 1'b1) : mm;
  assign dm   = (ovf_q || (quo_q > {1'b0, limv})) ? limv : quo_q[W-1:0];
  assign dres = sgn_q ? (~dm + 1'b1) : dm;
  assign msum = {1'b0, acc_q} + (mp_q[0] ? {1'b0, mc_q} : '0);
  assign r2   = {rem_q[W-1:0], dv_q[DN-1]};
  assign ge   = r2 >= {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (op_load) begin
      busy_q <= 1'b1;
      cnt_q  <= is_mul ? CW'(W) : CW'(DN);
    end else if (op_step) begin
      cnt_q <= cnt_q - 1'b1;
    end else if (op_done) begin
      busy_q <= 1'b0;
    end
  end

  // shift-add multiply and restoring divide, one bit per cycle
  always_ff @(posedge clk_i) begin
    if (op_load) begin
      if (is_mul) begin
        mc_q  <= mag_w(ma);
        mp_q  <= mag_w(mb);
        acc_q <= '0;
        sgn_q <= ma[W-1] ^ mb[W-1];
      end else begin
        dv_q  <= dvn;
        dd_q  <= ddn;
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        sgn_q <= dneg;
      end
    end else if (op_step) begin
      if (is_mul) begin
        acc_q <= msum[W:1];
        mp_q  <= {msum[0], mp_q[W-1:1]};
      end else begin
        rem_q <= ge ? (r2 - {1'b0, dd_q}) : r2;
        dv_q  <= dv_q << 1;
        ovf_q <= ovf_q | quo_q[W];
        quo_q <= {quo_q[W-1:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------- loop datapath
  logic signed [W-1:0] bnd, integ_c;
  logic signed [W+1:0] total;

  assign bnd = !bnd_skip_c ? dres : (span_le0 ? '0 : MAXV);

  always_comb begin
    integ_c = integ_q;
    if (integ_q > bnd) integ_c = bnd;
    else if (integ_q < -bnd) integ_c = -bnd;
  end

  assign total = {{2{p_q[W-1]}}, p_q} + {{2{i_q[W-1]}}, i_q} + {{2{d_q[W-1]}}, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
      filt_q  <= '0;
    end else begin
      if (state_q == ST_TMUL && op_done)
        integ_q <= sat_w1({integ_q[W-1], integ_q} + {mres[W-1], mres});
      if (state_q == ST_BND && (op_done || (!busy_q && bnd_skip_c)))
        integ_q <= integ_c;
      if (state_q == ST_FDIV && op_done) filt_q <= dres;
      if (state_q == ST_SUM && out_free) last_q <= e_q;
      if (state_q == ST_CLR && out_free) begin
        integ_q <= '0;
        last_q  <= '0;
        filt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) e_q <= sat_w1(e_full);
    if (op_done) begin
      unique case (state_q)
        ST_PMUL: p_q   <= mres;
        ST_IMUL: i_q   <= mres;
        ST_DMUL: d_q   <= mres;
        ST_RDIV: raw_q <= dres;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (out_wr) begin
      mv_q <= 1'b1;
    end else if (m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      if (state_q == ST_CLR) begin
        md_q <= '0;
        ml_q <= 1'b0;
      end else if (total > $signed({{2{oh_q[W-1]}}, oh_q})) begin
        md_q <= oh_q;
        ml_q <= 1'b1;
      end else if (total < $signed({{2{ol_q[W-1]}}, ol_q})) begin
        md_q <= ol_q;
        ml_q <= 1'b1;
      end else begin
        md_q <= total[W-1:0];
        ml_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = ODW'({1'b0, md_q} & {1'b0, {W{1'b1}}});
  assign m_axis_tuser  = ml_q;

endmodule

@@ src/psc_checker.sv @@
module psc_sva #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  input logic                                m_axis_tuser
);
  import psc_pkg::*;

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  // one item at a time: input closes right after a beat is taken
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // no result appears in the cycle right after an input beat
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // a clear beat taken while no result waits gives a zero unlimited result
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_CLEAR && !m_axis_tvalid
    |=> ##1 m_axis_tvalid && m_axis_tdata == '0 && !m_axis_tuser)
    else $error("clear result wrong");

endmodule

bind pid_speed_controller psc_sva #(
  .DATA_WIDTH(DATA_WIDTH)
) u_psc_sva (.*);

@@ verif/psc_checker.sv @@
`timescale 1ns / 100ps

module psc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  input  logic        out_user_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          limited_o
);
  import psc_pkg::*;

  localparam longint DMAX = 64'sd2147483647;
  localparam longint DMIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] drive;
    logic        limited;
  } drive_t;

  longint kp, ki, kd, lo_lim, hi_lim, period;
  longint integ_acc, prev_err, deriv_filt;
  drive_t drive_q[$];

  function automatic longint sat32(longint x);
    if (x > DMAX) return DMAX;
    if (x < DMIN) return DMIN;
    return x;
  endfunction

  // (a*b) >> 16 on magnitudes, toward zero, saturated
  function automatic longint fx_mul(longint a, longint b);
    logic         neg;
    logic [127:0] prod;
    logic [127:0] lim;
    neg  = (a < 0) != (b < 0);
    prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    prod = prod >> 16;
    lim  = neg ? 128'd2147483648 : 128'd2147483647;
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // (x << 16) / d on magnitudes, toward zero, saturated
  function automatic longint fx_div(longint x, longint d);
    logic         neg;
    logic [127:0] q;
    logic [127:0] lim;
    neg = x < 0;
    q   = (128'(x < 0 ? -x : x) << 16) / 128'(d);
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic drive_t pid_step(logic [31:0] sp, logic [31:0] meas);
    longint err, pterm, iterm, dterm, raw, bound, span, total, per;
    drive_t r;
    per   = (period != 0) ? period : 1;
    err   = sat32(longint'($signed(sp)) - longint'($signed(meas)));
    pterm = fx_mul(kp, err);
    integ_acc = sat32(integ_acc + fx_mul(err, per));
    span = hi_lim - lo_lim;
    if (span <= 0) bound = 0;
    else if (ki == 0) bound = DMAX;
    else bound = fx_div(span, ki < 0 ? -ki : ki);
    if (integ_acc > bound) integ_acc = bound;
    else if (integ_acc < -bound) integ_acc = -bound;
    iterm = fx_mul(ki, integ_acc);
    raw = fx_div(err - prev_err, per);
    deriv_filt = sat32((4 * deriv_filt + raw) / 5);
    dterm = fx_mul(kd, deriv_filt);
    total = pterm + iterm + dterm;
    r.limited = 1'b0;
    if (total > hi_lim) begin
      total = hi_lim;
      r.limited = 1'b1;
    end else if (total < lo_lim) begin
      total = lo_lim;
      r.limited = 1'b1;
    end
    prev_err = err;
    r.drive  = total[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_t want;
    if (!rst_ni) begin
      kp = 0; ki = 0; kd = 0; period = 66;
      lo_lim = -64'sd65536000; hi_lim = 64'sd65536000;
      integ_acc = 0; prev_err = 0; deriv_filt = 0;
      drive_q.delete();
      fail_count_o <= 0;
      results_o <= 0;
      limited_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PROP_GAIN:  kp = longint'($signed(cfg_data_i));
          REG_INTEG_GAIN: ki = longint'($signed(cfg_data_i));
          REG_DERIV_GAIN: kd = longint'($signed(cfg_data_i));
          REG_PERIOD:     period = longint'(cfg_data_i[30:0]);
          REG_OUT_LOW:    lo_lim = longint'($signed(cfg_data_i));
          REG_OUT_HIGH:   hi_lim = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_user_i == REQ_CLEAR) begin
          integ_acc = 0; prev_err = 0; deriv_filt = 0;
          drive_q.push_back('0);
        end else begin
          drive_q.push_back(pid_step(in_data_i[31:0], in_data_i[63:32]));
        end
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (out_user_i) limited_o <= limited_o + 1;
        if (drive_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result beat %h", out_data_i);
        end else begin
          want = drive_q.pop_front();
          if (want.drive !== out_data_i || want.limited !== out_user_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("drive mismatch: exp %h/%b got %h/%b", want.drive, want.limited,
                       out_data_i, out_user_i);
          end
        end
      end
    end
    pending_o <= drive_q.size();
  end

endmodule

@@ verif/tb_pid_speed_controller.sv @@
`timescale 1ns / 100ps

module tb_pid_speed_controller;
  import psc_pkg::*;

  localparam int N_RANDOM = 1990;
  localparam int LATENCY  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count, pending, results, limited_cnt;
  bit hold_off = 1'b0;  // long receiver stall in progress
  int step_cnt = 0, clear_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pid_speed_controller dut (.*);

  psc_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_user_i(s_axis_tuser),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata), .out_user_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending),
    .results_o(results), .limited_o(limited_cnt)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
  end

  // draws for the operands: extremes, zero or minus one, values within +/-1000.0 in Q16.16, full range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      3, 4: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
      default: return $urandom();
    endcase
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_beat(logic kind, logic [31:0] sp, logic [31:0] meas);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {meas, sp};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == REQ_CLEAR) clear_cnt++;
    else step_cnt++;
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // let every expected result drain, then extra cycles for a step still in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic load_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] per,
                            logic [31:0] lo, logic [31:0] hi);
    cfg_write(REG_PROP_GAIN, p);
    cfg_write(REG_INTEG_GAIN, i);
    cfg_write(REG_DERIV_GAIN, d);
    cfg_write(REG_PERIOD, per);
    cfg_write(REG_OUT_LOW, lo);
    cfg_write(REG_OUT_HIGH, hi);
  endtask

  task automatic random_run(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) send_beat(REQ_CLEAR, $urandom(), $urandom());
      else send_beat(REQ_STEP, pick_value(), pick_value());
      idle_gap();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default registers, field extremes and both requests
    send_beat(REQ_STEP, 32'h0, 32'h0);
    send_beat(REQ_STEP, 32'h7fffffff, 32'h80000000);
    send_beat(REQ_STEP, 32'h80000000, 32'h7fffffff);
    send_beat(REQ_STEP, 32'h00010000, 32'h0);
    send_beat(REQ_CLEAR, 32'hffffffff, 32'hffffffff);
    send_beat(REQ_STEP, 32'hffffffff, 32'h0);
    drain();

    // unit gains, zero period, then negative integral gain and unordered limits
    load_gains(32'h00010000, 32'h00010000, 32'h00010000, 32'h0, 32'hffff0000, 32'h00010000);
    send_beat(REQ_CLEAR, 32'h0, 32'h0);
    send_beat(REQ_STEP, 32'h00050000, 32'h0);
    send_beat(REQ_STEP, 32'h7fffffff, 32'h0);
    send_beat(REQ_STEP, 32'h80000000, 32'h00000001);
    drain();
    load_gains(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h00100000,
               32'h00100000);
    send_beat(REQ_CLEAR, 32'h0, 32'h0);
    send_beat(REQ_STEP, 32'h12345678, 32'h87654321);
    send_beat(REQ_STEP, 32'h0, 32'h0);
    drain();
    cfg_write(REG_OUT_HIGH, 32'h80000000);
    cfg_write(REG_OUT_LOW, 32'h7fffffff);
    send_beat(REQ_STEP, 32'h00020000, 32'h00010000);
    drain();

    // random phases over several gain and limit settings
    for (int ph = 0; ph < 6; ph++) begin
      load_gains($urandom(), (ph == 2) ? 32'h0 : 32'($signed($urandom_range(0, 1 << 18)) - 65536),
                 32'($signed($urandom_range(0, 1 << 17)) - 32768),
                 (ph == 3) ? 32'h7fffffff : $urandom_range(1, 1 << 14),
                 (ph == 4) ? 32'h80000000 : -$urandom_range(0, 1 << 26),
                 (ph == 4) ? 32'h7fffffff : $urandom_range(0, 1 << 26));
      send_beat(REQ_CLEAR, 32'h0, 32'h0);
      random_run(N_RANDOM / 6 - 20);
      // long receiver hold-off while beats keep coming
      hold_off = 1'b1;
      fork
        random_run(10);
        begin
          repeat (800) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join
      drain();
    end

    $display("covered %0d steps and %0d clears over default, directed and random registers",
             step_cnt, clear_cnt);
    $display("checked %0d results, %0d of them clamped", results, limited_cnt);
    if (fail_count == 0) $display("pid_speed_controller test passed");
    else $display("pid_speed_controller test failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("pid_speed_controller test failed");
    $finish;
  end

endmodule
